/* rtl/sfd_pkg.sv */
// Shared constants, command and status types for the serial frame deframer.
package sfd_pkg;

  localparam int MaxPayload = 32;
  localparam int IdxW       = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int BodyLenW   = 9;

  localparam logic [7:0] StartByte   = 8'h68;
  localparam logic [7:0] EndByte     = 8'h16;
  localparam logic [7:0] PayloadBias = 8'h33;
  localparam logic [7:0] AddrCheck   = 8'hFF;
  localparam logic [BodyLenW-1:0] BodyLenMax = {BodyLenW{1'b1}};

  // Controller to datapath; the byte commands are already qualified by the word handshake.
  typedef struct packed {
    logic load_addr;
    logic load_inv;
    logic start_body;
    logic body_byte;
    logic emit_start;
    logic rd;
    logic load_out;
    logic next_idx;
  } sfd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic start_hit;
    logic head_ok;
    logic count_bad;
    logic frame_end;
    logic frame_good;
    logic last;
    logic out_free;
  } sfd_status_t;

endpackage

/* rtl/sfd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module sfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sfd_datapath.sv */
// Datapath: head and body registers, checksum, payload store and output register.
module sfd_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          data_byte_i,
  input  sfd_pkg::sfd_cmd_t   cmd_i,
  output sfd_pkg::sfd_status_t status_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [7:0]          frame_address_o,
  output logic [7:0]          frame_operation_o,
  output logic [5:0]          payload_length_o,
  output logic [4:0]          payload_position_o,
  output logic [7:0]          payload_value_o,
  output logic                last_of_frame_o
);
  import sfd_pkg::*;

  logic [7:0]          addr_q, inv_q, op_q, count_q, sum_q, ck_q;
  logic                eok_q;
  logic [BodyLenW-1:0] len_q;
  logic [IdxW-1:0]     idx_q;

  logic [BodyLenW-1:0] pos, cnt_eff, len_d;
  logic                is_op, is_cnt, is_pay, is_ck, is_end;
  logic [7:0]          sum_d, ck_d;
  logic                eok_d;
  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  logic [7:0]          ram_rdata;
  logic                last;

  logic                out_valid_q;
  logic [7:0]          o_addr_q, o_op_q, o_val_q;
  logic [5:0]          o_len_q;
  logic [4:0]          o_pos_q;
  logic                o_last_q;

  // Body position decode; the count byte itself sets the count it is checked against.
  always_comb begin
    pos     = len_q;
    cnt_eff = (pos == BodyLenW'(1)) ? BodyLenW'(data_byte_i) : BodyLenW'(count_q);
    is_op   = (pos == '0);
    is_cnt  = (pos == BodyLenW'(1));
    is_pay  = !is_op && !is_cnt && (pos < cnt_eff + BodyLenW'(2));
    is_ck   = (pos == cnt_eff + BodyLenW'(2));
    is_end  = (pos == cnt_eff + BodyLenW'(3));
    len_d   = (len_q == BodyLenMax) ? len_q : len_q + BodyLenW'(1);
    sum_d   = (is_op || is_cnt || is_pay) ? sum_q + data_byte_i : sum_q;
    ck_d    = is_ck ? data_byte_i : ck_q;
    eok_d   = is_end ? (data_byte_i == EndByte) : eok_q;
  end

  assign ram_we    = cmd_i.body_byte && is_pay;
  assign ram_waddr = IdxW'(pos - BodyLenW'(2));

  assign last = (count_q == 8'd0) || ((8'(idx_q) + 8'd1) == count_q);

  always_comb begin
    status_o.start_hit  = (data_byte_i == StartByte);
    status_o.head_ok    = (data_byte_i == StartByte) && ((addr_q ^ inv_q) == AddrCheck);
    status_o.count_bad  = is_cnt && (data_byte_i > 8'(MaxPayload));
    status_o.frame_end  = (data_byte_i == EndByte) && (len_d >= cnt_eff + BodyLenW'(4));
    status_o.frame_good = eok_d && (ck_d == sum_d);
    status_o.last       = last;
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      inv_q    <= '0;
      op_q     <= '0;
      count_q  <= '0;
      len_q    <= '0;
      eok_q    <= 1'b0;
      sum_q    <= '0;
      ck_q     <= '0;
      idx_q    <= '0;
      o_addr_q <= '0;
      o_op_q   <= '0;
      o_len_q  <= '0;
      o_pos_q  <= '0;
      o_val_q  <= '0;
      o_last_q <= 1'b0;
    end else begin
      if (cmd_i.load_addr) begin
        addr_q <= data_byte_i;
      end
      if (cmd_i.load_inv) begin
        inv_q <= data_byte_i;
      end
      if (cmd_i.start_body) begin
        len_q <= '0;
        eok_q <= 1'b0;
        sum_q <= StartByte + addr_q + inv_q + StartByte;
      end else if (cmd_i.body_byte) begin
        len_q <= len_d;
        eok_q <= eok_d;
        sum_q <= sum_d;
        ck_q  <= ck_d;
        if (is_op) begin
          op_q <= data_byte_i;
        end
        if (is_cnt) begin
          count_q <= data_byte_i;
        end
      end
      if (cmd_i.emit_start) begin
        idx_q <= '0;
      end else if (cmd_i.next_idx) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.load_out) begin
        o_addr_q <= addr_q;
        o_op_q   <= op_q;
        o_len_q  <= 6'(count_q);
        o_pos_q  <= 5'(idx_q);
        o_val_q  <= (count_q == 8'd0) ? 8'd0 : ram_rdata - PayloadBias;
        o_last_q <= last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  sfd_ram #(
    .Width(8),
    .Depth(MaxPayload)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_byte_i),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o        = out_valid_q;
  assign frame_address_o    = o_addr_q;
  assign frame_operation_o  = o_op_q;
  assign payload_length_o   = o_len_q;
  assign payload_position_o = o_pos_q;
  assign payload_value_o    = o_val_q;
  assign last_of_frame_o    = o_last_q;

`ifndef SYNTH
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("output register load did not raise valid");
  a_write_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (len_q >= BodyLenW'(2)) && (count_q <= 8'(MaxPayload) || is_cnt))
    else $error("payload store written outside payload span");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_i.load_out)
    else $error("output register overwritten while held");
`endif

endmodule

/* rtl/sfd_ctrl.sv */
// Controller: head hunt, body sequencing and payload run emission.
module sfd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sfd_pkg::sfd_status_t status_i,
  output sfd_pkg::sfd_cmd_t    cmd_o
);
  import sfd_pkg::*;

  localparam logic [2:0] StHunt  = 3'd0;
  localparam logic [2:0] StAddr  = 3'd1;
  localparam logic [2:0] StInv   = 3'd2;
  localparam logic [2:0] StHEnd  = 3'd3;
  localparam logic [2:0] StBody  = 3'd4;
  localparam logic [2:0] StRd    = 3'd5;
  localparam logic [2:0] StLoad  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       emitting, acc;

  assign emitting   = (state_q == StRd) || (state_q == StLoad);
  assign in_stall_o = emitting;
  assign acc        = in_valid_i && !emitting;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StHunt: begin
        if (acc && status_i.start_hit) begin
          state_d = StAddr;
        end
      end
      StAddr: begin
        if (acc) begin
          cmd_o.load_addr = 1'b1;
          state_d         = StInv;
        end
      end
      StInv: begin
        if (acc) begin
          cmd_o.load_inv = 1'b1;
          state_d        = StHEnd;
        end
      end
      StHEnd: begin
        if (acc) begin
          if (status_i.head_ok) begin
            cmd_o.start_body = 1'b1;
            state_d          = StBody;
          end else begin
            state_d = StHunt;
          end
        end
      end
      StBody: begin
        if (acc) begin
          cmd_o.body_byte = 1'b1;
          priority if (status_i.count_bad) begin
            state_d = StHunt;
          end else if (status_i.frame_end && status_i.frame_good) begin
            cmd_o.emit_start = 1'b1;
            state_d          = StRd;
          end else if (status_i.frame_end) begin
            state_d = StHunt;
          end else begin
            state_d = StBody;
          end
        end
      end
      StRd: begin
        cmd_o.rd = 1'b1;
        state_d  = StLoad;
      end
      StLoad: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (status_i.last) begin
            state_d = StHunt;
          end else begin
            cmd_o.next_idx = 1'b1;
            state_d        = StRd;
          end
        end
      end
      default: begin
        state_d = StHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StHunt;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_emit_needs_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBody && state_d == StRd) |-> (status_i.frame_end && status_i.frame_good))
    else $error("emission started without a good frame");
  a_load_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad && !status_i.out_free) |=> (state_q == StLoad))
    else $error("left load state while output register busy");
  a_rd_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRd) |=> (state_q == StLoad))
    else $error("store read not followed by load");
`endif

endmodule

/* rtl/serial_frame_deframer_core.sv */
// Top level of the serial frame deframer: controller plus datapath.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------------
//  in      | in        | in_valid_i / in_stall_o  | data_byte_i (one received byte)
//  out     | out       | out_valid_o / out_stall_i| frame_address_o, frame_operation_o,
//          |           |                          | payload_length_o, payload_position_o,
//          |           |                          | payload_value_o, last_of_frame_o
//
// Outside a payload run an input word is accepted whenever in_valid_i is high; the byte
// decode and checksum update sit in one register stage of the datapath.
// A good frame's end byte starts a payload run: for each result word a store read,
// then an output register load, which waits while out_stall_i holds a word there.
// in_stall_o is high for the whole run; it drops once the last word sits in
// the output register, so new bytes flow while that word waits to be taken.
// rst_ni clears the controller state, the datapath registers and output valid;
// the payload store needs no clearing, since every entry whose value a good
// frame emits was written by it.
// Bad heads, oversized counts, bad end bytes and checksum mismatches drop
// the frame silently and resume the start-byte hunt.
module serial_frame_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_address_o,
  output logic [7:0] frame_operation_o,
  output logic [5:0] payload_length_o,
  output logic [4:0] payload_position_o,
  output logic [7:0] payload_value_o,
  output logic       last_of_frame_o
);
  import sfd_pkg::*;

  sfd_cmd_t    cmd;
  sfd_status_t status;

  // Sequencer: hunt, head, body, then the payload run.
  sfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Registers, checksum, payload store and output word register.
  sfd_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .data_byte_i        (data_byte_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .frame_address_o    (frame_address_o),
    .frame_operation_o  (frame_operation_o),
    .payload_length_o   (payload_length_o),
    .payload_position_o (payload_position_o),
    .payload_value_o    (payload_value_o),
    .last_of_frame_o    (last_of_frame_o)
  );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the serial frame deframer core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  // Cycles with no word accepted on either side before the run is declared hung.
  // The longest legal quiet stretch is the deliberate receiver hold below.
  localparam int QuietLimit   = 3000;
  localparam int HoldCycles   = 300;
  localparam int HoldAfter    = 10;   // results taken before the long hold starts
  localparam int TailCycles   = 80;   // lets any stray word show up at the end of the run
  localparam int MinBytes     = 150;
  localparam int MinGoodFrame = 4;

  // Phases of the software decoder that tracks the block.
  typedef enum logic [1:0] {
    ScanStart,
    TakeHead,
    TakeBody
  } rx_phase_e;

  // Frame shapes the stimulus generator can build.
  typedef enum logic [2:0] {
    FrGood,
    FrEarlyEnd,     // payload carries an end byte that must be kept as data
    FrBadChecksum,
    FrBadEnd,       // wrong byte at the end position, closed by a later end byte
    FrBadInverse,   // address and inverted address do not match
    FrBadTail,      // fourth head byte is not the start byte
    FrLongBody,     // wrong end byte, then a longer stretch of body bytes
    FrOverCount     // count above the payload limit
  } frame_kind_e;

  typedef struct packed {
    logic [7:0] address;
    logic [7:0] operation;
    logic [5:0] length;
    logic [4:0] position;
    logic [7:0] value;
    logic       last;
  } result_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] frame_address_o;
  logic [7:0] frame_operation_o;
  logic [5:0] payload_length_o;
  logic [4:0] payload_position_o;
  logic [7:0] payload_value_o;
  logic       last_of_frame_o;

  serial_frame_deframer_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .frame_address_o    (frame_address_o),
    .frame_operation_o  (frame_operation_o),
    .payload_length_o   (payload_length_o),
    .payload_position_o (payload_position_o),
    .payload_value_o    (payload_value_o),
    .last_of_frame_o    (last_of_frame_o)
  );

  // ---------------------------------------------------------------------------
  // Decoder state: a second, independent copy of the deframer's state.
  // ---------------------------------------------------------------------------
  rx_phase_e  rx_phase;
  logic [1:0] head_idx;
  logic [7:0] cur_addr;
  logic [7:0] cur_inv_addr;
  logic [7:0] cur_op;
  logic [7:0] cur_count;
  logic [7:0] cur_sum;
  logic [7:0] cur_checksum;
  logic [8:0] body_cnt;
  logic       end_pos_ok;
  logic [7:0] payload_mem [MaxPayload];

  // Result words the decoder has predicted and the block has not yet delivered.
  result_word_t pending_results[$];

  // Bytes still to send; a set drain flag makes the sender wait for an empty
  // prediction queue before offering that byte.
  logic [7:0] tx_bytes[$];
  bit         tx_drain[$];

  // Handshake bookkeeping shared between the edge processes.
  bit offering;
  bit byte_taken;
  bit word_taken;
  bit send_burst;
  bit recv_burst;
  bit hold_done;
  int send_gap;
  int recv_wait;
  int hold_left;
  int words_checked;
  int quiet_cycles;
  int fail_count;

  // Emit the payload run of a frame that passed every check.
  function automatic void emit_frame_words();
    result_word_t w;
    int           k;
    w.address   = cur_addr;
    w.operation = cur_op;
    if (cur_count == 8'd0) begin
      // Empty payload still yields a single closing word.
      w.length   = '0;
      w.position = '0;
      w.value    = '0;
      w.last     = 1'b1;
      pending_results.push_back(w);
    end else begin
      for (k = 0; k < int'(cur_count) && k < MaxPayload; k++) begin
        w.length   = 6'(cur_count);
        w.position = 5'(k);
        w.value    = 8'(payload_mem[k] - PayloadBias);
        w.last     = (k + 1 == int'(cur_count));
        pending_results.push_back(w);
      end
    end
  endfunction

  // Advance the decoder by one received byte; may queue a payload run.
  function automatic void decode_byte(input logic [7:0] b);
    int unsigned pos;
    int unsigned cnt;
    bit          dropped;
    pos     = body_cnt;
    cnt     = cur_count;
    dropped = 1'b0;
    case (rx_phase)
      TakeHead: begin
        if (head_idx == 2'd1) begin
          cur_addr = b;
          head_idx = 2'd2;
        end else if (head_idx == 2'd2) begin
          cur_inv_addr = b;
          head_idx     = 2'd3;
        end else begin
          // Closing head byte: a rejected head is not rescanned for a start byte.
          head_idx = 2'd0;
          if (b == StartByte && (cur_addr ^ cur_inv_addr) == AddrCheck) begin
            rx_phase   = TakeBody;
            body_cnt   = '0;
            end_pos_ok = 1'b0;
            cur_sum    = StartByte + cur_addr + cur_inv_addr + StartByte;
          end else begin
            rx_phase = ScanStart;
          end
        end
      end
      TakeBody: begin
        if (pos == 0) begin
          cur_op  = b;
          cur_sum = cur_sum + b;
        end else if (pos == 1) begin
          cur_count = b;
          cnt       = b;
          cur_sum   = cur_sum + b;
          if (cnt > MaxPayload) begin
            rx_phase = ScanStart;
            dropped  = 1'b1;
          end
        end else if (pos < cnt + 2) begin
          if (pos - 2 < MaxPayload) payload_mem[pos-2] = b;
          cur_sum = cur_sum + b;
        end else if (pos == cnt + 2) begin
          cur_checksum = b;
        end else if (pos == cnt + 3) begin
          end_pos_ok = (b == EndByte);
        end
        if (!dropped) begin
          if (body_cnt != BodyLenMax) body_cnt = body_cnt + 1'b1;
          // An end byte closes the frame only once the body is long enough.
          if (b == EndByte && int'(body_cnt) >= int'(cnt) + 4) begin
            rx_phase = ScanStart;
            if (end_pos_ok && cur_checksum == cur_sum) emit_frame_words();
          end
        end
      end
      default: begin
        rx_phase = ScanStart;
        if (b == StartByte) begin
          rx_phase = TakeHead;
          head_idx = 2'd1;
        end
      end
    endcase
  endfunction

  function automatic void push_byte(input logic [7:0] b, input bit drain_first);
    tx_bytes.push_back(b);
    tx_drain.push_back(drain_first);
  endfunction

  function automatic logic [7:0] rand_non_end();
    logic [7:0] b;
    do b = 8'($urandom); while (b == EndByte);
    return b;
  endfunction

  // Queue the bytes of one frame of the given shape.
  function automatic void queue_frame(input frame_kind_e kind, input logic [7:0] addr,
                                      input logic [7:0] op, input logic [7:0] cnt,
                                      input bit drain_first);
    logic [7:0] inv;
    logic [7:0] tail;
    logic [7:0] sum;
    logic [7:0] b;
    int         n_payload;
    int         extra;
    int         i;
    inv  = ~addr;
    tail = StartByte;
    if (kind == FrBadInverse) inv = inv ^ (8'h01 << $urandom_range(0, 7));
    if (kind == FrBadTail) begin
      do tail = 8'($urandom); while (tail == StartByte);
    end
    push_byte(StartByte, drain_first);
    push_byte(addr, 1'b0);
    push_byte(inv, 1'b0);
    push_byte(tail, 1'b0);
    push_byte(op, 1'b0);
    push_byte(cnt, 1'b0);
    sum       = StartByte + addr + inv + StartByte + op + cnt;
    n_payload = (kind == FrOverCount) ? $urandom_range(0, 3) : int'(cnt);
    for (i = 0; i < n_payload; i++) begin
      b = 8'($urandom);
      if (kind == FrEarlyEnd && i == 0) b = EndByte;
      push_byte(b, 1'b0);
      sum = sum + b;
    end
    if (kind != FrOverCount) begin
      if (kind == FrBadChecksum) sum = sum ^ 8'($urandom_range(1, 255));
      push_byte(sum, 1'b0);
      if (kind == FrBadEnd || kind == FrLongBody) begin
        push_byte(rand_non_end(), 1'b0);
        extra = (kind == FrLongBody) ? $urandom_range(6, 12) : $urandom_range(0, 3);
        repeat (extra) push_byte(rand_non_end(), 1'b0);
      end
      push_byte(EndByte, 1'b0);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Sender: offers the next queued byte at the falling edge, holds it until the
  // word is taken, then idles for a random number of cycles. Bursts with no gap
  // come and go at random.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (byte_taken) begin
        byte_taken = 1'b0;
        offering   = 1'b0;
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 15);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (tx_bytes.size() != 0 &&
                     !(tx_drain[0] && pending_results.size() != 0)) begin
          data_byte_i <= tx_bytes.pop_front();
          void'(tx_drain.pop_front());
          offering = 1'b1;
        end
      end
      in_valid_i <= offering;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stalls each result word a random number of valid cycles; once,
  // mid-run, it holds off for a long stretch so the block backs up into its
  // input while the sender keeps offering bytes.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    bit stall_now;
    if (rst_ni) begin
      if (word_taken) begin
        word_taken = 1'b0;
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 15);
      end
      if (!hold_done && words_checked >= HoldAfter) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else if (recv_wait > 0 && out_valid_o) begin
        recv_wait--;
        stall_now = 1'b1;
      end else begin
        stall_now = 1'b0;
      end
      out_stall_i <= stall_now;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, check a delivered word against the oldest
  // prediction, then feed an accepted input byte to the decoder. The output is
  // handled first, since a byte taken this edge cannot have a result out yet.
  // Also runs the hang watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_word_t want;
    if (rst_ni) begin
      quiet_cycles++;
      if (out_valid_o && !out_stall_i) begin
        quiet_cycles = 0;
        word_taken   = 1'b1;
        words_checked++;
        if (pending_results.size() == 0) begin
          $error("result word with no prediction pending: addr 0x%0h pos %0d",
                 frame_address_o, payload_position_o);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("frame_address", want.address, frame_address_o);
          check_field("frame_operation", want.operation, frame_operation_o);
          check_field("payload_length", want.length, payload_length_o);
          check_field("payload_position", want.position, payload_position_o);
          check_field("payload_value", want.value, payload_value_o);
          check_field("last_of_frame", want.last, last_of_frame_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        quiet_cycles = 0;
        byte_taken   = 1'b1;
        decode_byte(data_byte_i);
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    frame_kind_e forced_kinds [8];
    frame_kind_e kind;
    logic [7:0]  addr;
    logic [7:0]  op;
    logic [7:0]  cnt;
    int          frame_idx;
    int          good_frames;
    int          pick;

    in_valid_i  = 1'b0;
    data_byte_i = '0;
    out_stall_i = 1'b0;
    rst_ni      = 1'b0;

    rx_phase     = ScanStart;
    head_idx     = '0;
    cur_addr     = '0;
    cur_inv_addr = '0;
    cur_op       = '0;
    cur_count    = '0;
    cur_sum      = '0;
    cur_checksum = '0;
    body_cnt     = '0;
    end_pos_ok   = 1'b0;

    // Directed: empty payload at the lowest address and op, a head whose
    // address and inverse are both the start byte, and the largest count.
    queue_frame(FrGood, 8'h00, 8'h00, 8'd0, 1'b0);
    repeat (4) push_byte(StartByte, 1'b0);
    queue_frame(FrOverCount, 8'hFF, 8'hFF, 8'hFF, 1'b0);

    // Random frames: every shape appears first in turn (a full 32-byte payload
    // at the top address leads), then mostly good frames with some damage.
    forced_kinds = '{FrGood, FrEarlyEnd, FrBadChecksum, FrBadEnd,
                     FrBadInverse, FrBadTail, FrLongBody, FrOverCount};
    frame_idx   = 0;
    good_frames = 0;
    while (tx_bytes.size() < MinBytes || good_frames < MinGoodFrame) begin
      if (frame_idx < 8) begin
        kind = forced_kinds[frame_idx];
      end else begin
        pick = $urandom_range(0, 11);
        if (pick < 7)        kind = FrGood;
        else if (pick == 7)  kind = FrEarlyEnd;
        else if (pick == 8)  kind = FrBadChecksum;
        else if (pick == 9)  kind = FrBadEnd;
        else if (pick == 10) kind = FrOverCount;
        else                 kind = $urandom_range(0, 1) ? FrBadInverse : FrBadTail;
      end
      addr = 8'($urandom);
      op   = 8'($urandom);
      if (kind == FrOverCount) begin
        cnt = 8'($urandom_range(MaxPayload + 1, 255));
      end else if ($urandom_range(0, 9) == 0) begin
        cnt = 8'($urandom_range(0, MaxPayload));
      end else begin
        cnt = 8'($urandom_range(0, 6));
      end
      if (frame_idx == 0) begin
        addr = 8'hFF;
        op   = 8'hFF;
        cnt  = 8'(MaxPayload);
      end
      if (kind == FrEarlyEnd && cnt == 8'd0) cnt = 8'd1;
      if (kind == FrGood || kind == FrEarlyEnd) good_frames++;
      // Line noise between frames now and then.
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
      end
      // Every ninth frame waits for the block to go fully quiet first.
      queue_frame(kind, addr, op, cnt, (frame_idx % 9) == 4);
      frame_idx++;
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (tx_bytes.size() != 0 || offering) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    // Let any stray word show up before calling it.
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d predicted result words never arrived", pending_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
